### rtl/core/gif_lzw_compressor_core_macros.svh
// Assertion macros for the GIF LZW compressor core.
// Used by gif_lzw_compressor_core.sv; expects aclk and aresetn in scope.
`ifndef GIF_LZW_COMPRESSOR_CORE_MACROS_SVH
`define GIF_LZW_COMPRESSOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GLC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("compressor core check failed");

// Next-cycle implication, checked outside reset.
`define GLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("compressor core check failed");

`endif

### rtl/core/glc_pkg.sv
// Shared types and constants of the GIF LZW compressor core.
// No dependencies; imported by gif_lzw_compressor_core.
`default_nettype none

package glc_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int KEY_W         = 8 + MAX_CODE_BITS;
    localparam int TAG_W         = 4;
    localparam int TRK_W         = 13;
    localparam int ACC_W         = 20;
    localparam int NB_W          = 5;
    localparam int HASH_SHIFT    = 4;

    // Table generations; tag zero marks an entry left by a clearing pass.
    localparam logic [TAG_W-1:0] EPOCH_FIRST = 4'd1;
    localparam logic [TAG_W-1:0] EPOCH_LAST  = 4'd15;

    // Configuration register indexes.
    localparam logic [0:0] CFG_CODE_BITS = 1'b0;
    localparam logic [0:0] CFG_PACKETIZE = 1'b1;

    localparam logic [3:0] CODE_BITS_MIN = 4'd2;
    localparam logic [3:0] CODE_BITS_MAX = 4'd9;
    localparam logic [3:0] CODE_BITS_RST = 4'd9;

    localparam logic [TRK_W-1:0] TRK_SAT    = 13'd8191;
    localparam logic [TRK_W-1:0] DICT_LIMIT = 13'd4096;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [KEY_W-1:0]  key;
        logic [CODE_W-1:0] code;
    } hash_entry_t;

    typedef enum logic [17:0] {
        S_SWEEP   = 18'h00001,
        S_IDLE    = 18'h00002,
        S_HDR     = 18'h00004,
        S_CLR     = 18'h00008,
        S_SEND    = 18'h00010,
        S_PUT     = 18'h00020,
        S_PATCH   = 18'h00040,
        S_PRB_RD  = 18'h00080,
        S_PRB_CMP = 18'h00100,
        S_UPD     = 18'h00200,
        S_PFX     = 18'h00400,
        S_AFTER   = 18'h00800,
        S_CL1     = 18'h01000,
        S_CL2     = 18'h02000,
        S_FLUSH   = 18'h04000,
        S_LEN     = 18'h08000,
        S_TERM    = 18'h10000,
        S_FIN     = 18'h20000
    } state_t;

    // Code width from the tracker: bit length, at least 2, capped at 12.
    function automatic logic [3:0] code_width(input logic [TRK_W-1:0] trk);
        logic [3:0] w;
        w = 4'd2;
        for (int b = 2; b <= MAX_CODE_BITS - 2; b++) begin
            if (trk[b]) begin
                w = 4'(b + 1);
            end
        end
        if (trk[12] || trk[11]) begin
            w = 4'(MAX_CODE_BITS);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/gif_lzw_compressor_core.sv
// GIF LZW compressor core: one pixel index per request in, byte writes out.
// Depends on glc_pkg and gif_lzw_compressor_core_macros.svh.
//
// The block handles one pixel request at a time. A pixel whose string is
// already in the dictionary goes through accept, table read, compare, end
// check and finish; each further hash probe adds a table read and a compare,
// since every probe is a read of the single hash memory followed by a compare. A
// dictionary miss adds a step to merge the code, one to update the table
// and one per byte written; a full dictionary adds the clear step and
// another code merge. Every result byte passes through the output register.
// After reset, and on every fifteenth table clear, a clearing pass walks all
// HASH_DEPTH entries (5003 by default) of the hash memory, one entry per cycle;
// during the pass after reset no pixel is accepted. Other table clears only
// advance a generation tag. Configuration writes are always taken.
`default_nettype none

`include "gif_lzw_compressor_core_macros.svh"

module gif_lzw_compressor_core #(
    parameter int HASH_DEPTH    = 5003,
    parameter int OUT_ADDR_BITS = 16
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire  [7:0]               s_pixel,
    input  wire                      s_first_pixel,
    input  wire                      s_last_pixel,
    output logic                     m_valid,
    input  wire                      m_ready,
    output logic [OUT_ADDR_BITS-1:0] m_out_addr,
    output logic [7:0]               m_out_byte,
    output logic                     m_run_end,
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire  [0:0]               cfg_index,
    input  wire  [3:0]               cfg_data
);
    import glc_pkg::*;

    localparam int IDX_W = $clog2(HASH_DEPTH);
    localparam int K_W   = $clog2(HASH_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HASH_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(HASH_DEPTH);
    localparam logic [K_W-1:0]   DEPTH_K  = K_W'(HASH_DEPTH);
    localparam logic [OUT_ADDR_BITS-1:0] ONE_A = OUT_ADDR_BITS'(1);

    // Hash memory and its registered read port.
    hash_entry_t mem [HASH_DEPTH];
    hash_entry_t rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    hash_entry_t       mem_wd;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic             boot_reg, boot_next;
    logic [IDX_W-1:0] sweep_reg, sweep_next;
    logic [TAG_W-1:0] epoch_reg, epoch_next;
    logic [3:0]       cbits_reg, cbits_next;
    logic             pkcfg_reg, pkcfg_next;
    logic             open_reg, open_next;
    logic [3:0]       n_reg, n_next;
    logic [8:0]       clear_reg, clear_next;
    logic             pk_reg, pk_next;
    logic [7:0]       pix_reg, pix_next;
    logic             last_reg, last_next;
    logic [CODE_W-1:0] prefix_reg, prefix_next;
    logic [TRK_W-1:0] nfc_reg, nfc_next;
    logic [TRK_W-1:0] trk_reg, trk_next;
    logic [2:0]       bo_reg, bo_next;
    logic [7:0]       partial_reg, partial_next;
    logic [OUT_ADDR_BITS-1:0] wp_reg, wp_next;
    logic [7:0]       bc_reg, bc_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [NB_W-1:0]  nb_reg, nb_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] disp_reg, disp_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic             slot_reg, slot_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [OUT_ADDR_BITS-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_ADDR_BITS-1:0] m_addr_reg, m_addr_next;
    logic [7:0]       m_byte_reg, m_byte_next;
    logic             m_end_reg, m_end_next;

    logic             out_free, can_emit, emit_en, fin_push;
    logic [OUT_ADDR_BITS-1:0] emit_addr;
    logic [7:0]       emit_byte;
    logic [3:0]       n_eff;
    logic [8:0]       clear_new;
    logic [7:0]       mask8, c_in, pix_c;
    logic [11:0]      i0;
    logic [KEY_W-1:0] key_w;
    logic [IDX_W:0]   wrap_sum;
    logic [IDX_W-1:0] idx_step;
    logic [3:0]       w_v;
    logic [ACC_W-1:0] acc_s, acc_sh;
    logic [NB_W-1:0]  nb_s, nb_sh;
    logic [TRK_W-1:0] trk_inc;

    assign s_ready    = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_out_addr = m_addr_reg;
    assign m_out_byte = m_byte_reg;
    assign m_run_end  = m_end_reg;

    // Working values shared by several states.
    always_comb begin
        n_eff = cbits_reg;
        if (cbits_reg < CODE_BITS_MIN) begin
            n_eff = CODE_BITS_MIN;
        end else if (cbits_reg > CODE_BITS_MAX) begin
            n_eff = CODE_BITS_MAX;
        end
        clear_new = 9'd1 << (n_eff - 4'd1);
        mask8     = 8'(clear_reg - 9'd1);
        c_in      = s_pixel & mask8;
        pix_c     = pix_reg & mask8;
        i0        = (12'(c_in) << HASH_SHIFT) ^ prefix_reg;
        key_w     = {pix_c, prefix_reg};
        wrap_sum  = (IDX_W + 1)'(idx_reg) + DEPTH_X - (IDX_W + 1)'(disp_reg);
        idx_step  = (idx_reg >= disp_reg) ? (idx_reg - disp_reg) : wrap_sum[IDX_W-1:0];
        w_v       = code_width(trk_reg);
        acc_s     = (ACC_W'(code_reg) << bo_reg) | ACC_W'(partial_reg);
        nb_s      = NB_W'(w_v) + NB_W'(bo_reg);
        acc_sh    = acc_reg >> 8;
        nb_sh     = nb_reg - NB_W'(8);
        trk_inc   = (trk_reg == TRK_SAT) ? trk_reg : trk_reg + 13'd1;
        out_free  = !m_valid_reg || m_ready;
        can_emit  = !pend_valid_reg || out_free;
    end

    // Main sequencer.
    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        boot_next    = boot_reg;
        sweep_next   = sweep_reg;
        epoch_next   = epoch_reg;
        cbits_next   = cbits_reg;
        pkcfg_next   = pkcfg_reg;
        open_next    = open_reg;
        n_next       = n_reg;
        clear_next   = clear_reg;
        pk_next      = pk_reg;
        pix_next     = pix_reg;
        last_next    = last_reg;
        prefix_next  = prefix_reg;
        nfc_next     = nfc_reg;
        trk_next     = trk_reg;
        bo_next      = bo_reg;
        partial_next = partial_reg;
        wp_next      = wp_reg;
        bc_next      = bc_reg;
        code_next    = code_reg;
        acc_next     = acc_reg;
        nb_next      = nb_reg;
        idx_next     = idx_reg;
        disp_next    = disp_reg;
        k_next       = k_reg;
        slot_next    = slot_reg;
        mem_we       = 1'b0;
        mem_wa       = idx_reg;
        mem_wd       = '{tag: epoch_reg, key: key_w, code: nfc_reg[CODE_W-1:0]};
        emit_en      = 1'b0;
        emit_addr    = wp_reg;
        emit_byte    = 8'd0;
        fin_push     = 1'b0;

        // Configuration writes.
        if (cfg_valid) begin
            if (cfg_index == CFG_CODE_BITS) begin
                cbits_next = cfg_data;
            end else begin
                pkcfg_next = cfg_data[0];
            end
        end

        case (state_reg)
            S_SWEEP: begin
                mem_we = 1'b1;
                mem_wa = sweep_reg;
                mem_wd = '0;
                if (sweep_reg == LAST_IDX) begin
                    state_next = boot_reg ? S_IDLE : S_SEND;
                    boot_next  = 1'b0;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    pix_next  = s_pixel;
                    last_next = s_last_pixel;
                    if (s_first_pixel) begin
                        n_next       = n_eff;
                        clear_next   = clear_new;
                        pk_next      = pkcfg_reg;
                        wp_next      = '0;
                        bc_next      = 8'd0;
                        bo_next      = 3'd0;
                        partial_next = 8'd0;
                        nfc_next     = TRK_W'(clear_new) + 13'd2;
                        trk_next     = TRK_W'(clear_new);
                        ret_next     = S_PFX;
                        state_next   = pkcfg_reg ? S_HDR : S_CLR;
                    end else if (open_reg) begin
                        idx_next   = IDX_W'(i0);
                        disp_next  = (i0 == 12'd0) ? IDX_W'(1) :
                                     (DEPTH_X[IDX_W-1:0] - IDX_W'(i0));
                        k_next     = '0;
                        state_next = S_PRB_RD;
                    end
                end
            end
            // Code-size byte; the first length byte is left for the patch.
            S_HDR: begin
                if (can_emit) begin
                    emit_en    = 1'b1;
                    emit_addr  = '0;
                    emit_byte  = 8'(n_reg) - 8'd1;
                    wp_next    = OUT_ADDR_BITS'(2);
                    state_next = S_CLR;
                end
            end
            // Table clear: next generation, or a clearing pass after the last; then send the clear code.
            S_CLR: begin
                code_next = CODE_W'(clear_reg);
                if (epoch_reg == EPOCH_LAST) begin
                    epoch_next = EPOCH_FIRST;
                    sweep_next = '0;
                    state_next = S_SWEEP;
                end else begin
                    epoch_next = epoch_reg + 1'b1;
                    state_next = S_SEND;
                end
            end
            // Merge one code into the bit accumulator.
            S_SEND: begin
                trk_next = trk_inc;
                if (code_reg == CODE_W'(clear_reg)) begin
                    trk_next = TRK_W'(clear_reg) + 13'd1;
                end
                acc_next = acc_s;
                nb_next  = nb_s;
                if (nb_s >= NB_W'(8)) begin
                    state_next = S_PUT;
                end else begin
                    bo_next      = nb_s[2:0];
                    partial_next = (nb_s[2:0] != 3'd0) ? acc_s[7:0] : 8'd0;
                    state_next   = ret_reg;
                end
            end
            // Write one finished byte; a full sub-block needs its length patched.
            S_PUT: begin
                if (can_emit) begin
                    emit_en   = 1'b1;
                    emit_byte = acc_reg[7:0];
                    wp_next   = wp_reg + ONE_A;
                    acc_next  = acc_sh;
                    nb_next   = nb_sh;
                    if (pk_reg && bc_reg == 8'd254) begin
                        bc_next    = 8'd0;
                        state_next = S_PATCH;
                    end else begin
                        if (pk_reg) begin
                            bc_next = bc_reg + 8'd1;
                        end
                        if (nb_sh < NB_W'(8)) begin
                            bo_next      = nb_sh[2:0];
                            partial_next = (nb_sh[2:0] != 3'd0) ? acc_sh[7:0] : 8'd0;
                            state_next   = ret_reg;
                        end
                    end
                end
            end
            S_PATCH: begin
                if (can_emit) begin
                    emit_en   = 1'b1;
                    emit_addr = wp_reg - OUT_ADDR_BITS'(256);
                    emit_byte = 8'hFF;
                    wp_next   = wp_reg + ONE_A;
                    if (nb_reg >= NB_W'(8)) begin
                        state_next = S_PUT;
                    end else begin
                        bo_next      = nb_reg[2:0];
                        partial_next = (nb_reg[2:0] != 3'd0) ? acc_reg[7:0] : 8'd0;
                        state_next   = ret_reg;
                    end
                end
            end
            S_PRB_RD: begin
                state_next = S_PRB_CMP;
            end
            // Compare the probed entry: hit, empty slot, all probes used, or step on.
            S_PRB_CMP: begin
                if (rd_data_reg.tag == epoch_reg && rd_data_reg.key == key_w) begin
                    prefix_next = rd_data_reg.code;
                    state_next  = S_AFTER;
                end else if (rd_data_reg.tag != epoch_reg || k_reg == DEPTH_K) begin
                    slot_next  = (rd_data_reg.tag != epoch_reg);
                    code_next  = prefix_reg;
                    ret_next   = S_UPD;
                    state_next = S_SEND;
                end else begin
                    idx_next   = idx_step;
                    k_next     = k_reg + 1'b1;
                    state_next = S_PRB_RD;
                end
            end
            // Store the new string if an empty slot was found, or clear a full dictionary.
            S_UPD: begin
                prefix_next = CODE_W'(pix_c);
                if (nfc_reg < DICT_LIMIT) begin
                    mem_we     = slot_reg;
                    nfc_next   = nfc_reg + 13'd1;
                    state_next = S_AFTER;
                end else begin
                    nfc_next   = TRK_W'(clear_reg) + 13'd2;
                    ret_next   = S_AFTER;
                    state_next = S_CLR;
                end
            end
            S_PFX: begin
                prefix_next = CODE_W'(pix_c);
                open_next   = 1'b1;
                state_next  = S_AFTER;
            end
            S_AFTER: begin
                state_next = last_reg ? S_CL1 : S_FIN;
            end
            S_CL1: begin
                code_next  = prefix_reg;
                ret_next   = S_CL2;
                state_next = S_SEND;
            end
            S_CL2: begin
                code_next  = CODE_W'(clear_reg) + 12'd1;
                ret_next   = S_FLUSH;
                state_next = S_SEND;
            end
            S_FLUSH: begin
                if (bo_reg != 3'd0) begin
                    acc_next   = ACC_W'(partial_reg);
                    nb_next    = NB_W'(8);
                    ret_next   = S_LEN;
                    state_next = S_PUT;
                end else begin
                    state_next = S_LEN;
                end
            end
            // In packet mode, patch the last sub-block length and, if it is not empty, add the terminator.
            S_LEN: begin
                open_next = 1'b0;
                if (!pk_reg) begin
                    state_next = S_FIN;
                end else if (can_emit) begin
                    emit_en    = 1'b1;
                    emit_addr  = wp_reg - OUT_ADDR_BITS'(bc_reg) - ONE_A;
                    emit_byte  = bc_reg;
                    state_next = (bc_reg != 8'd0) ? S_TERM : S_FIN;
                end
            end
            S_TERM: begin
                if (can_emit) begin
                    emit_en    = 1'b1;
                    emit_byte  = 8'd0;
                    wp_next    = wp_reg + ONE_A;
                    state_next = S_FIN;
                end
            end
            // Release the held byte as the last one of this request.
            S_FIN: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    fin_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // One byte is held back so the final byte of a request can be flagged.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_byte_next  = pend_byte_reg;
        m_valid_next    = m_valid_reg;
        m_addr_next     = m_addr_reg;
        m_byte_next     = m_byte_reg;
        m_end_next      = m_end_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit_en) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_addr_next  = pend_addr_reg;
                m_byte_next  = pend_byte_reg;
                m_end_next   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_addr_next  = emit_addr;
            pend_byte_next  = emit_byte;
        end
        if (fin_push) begin
            m_valid_next    = 1'b1;
            m_addr_next     = pend_addr_reg;
            m_byte_next     = pend_byte_reg;
            m_end_next      = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // Hash memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[idx_reg];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_SWEEP;
            ret_reg        <= S_IDLE;
            boot_reg       <= 1'b1;
            sweep_reg      <= '0;
            epoch_reg      <= EPOCH_FIRST;
            cbits_reg      <= CODE_BITS_RST;
            pkcfg_reg      <= 1'b1;
            open_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            nfc_reg        <= 13'd258;
            trk_reg        <= 13'd256;
            clear_reg      <= 9'd256;
            prefix_reg     <= '0;
            bo_reg         <= 3'd0;
            partial_reg    <= 8'd0;
            wp_reg         <= '0;
            bc_reg         <= 8'd0;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            boot_reg       <= boot_next;
            sweep_reg      <= sweep_next;
            epoch_reg      <= epoch_next;
            cbits_reg      <= cbits_next;
            pkcfg_reg      <= pkcfg_next;
            open_reg       <= open_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            nfc_reg        <= nfc_next;
            trk_reg        <= trk_next;
            clear_reg      <= clear_next;
            prefix_reg     <= prefix_next;
            bo_reg         <= bo_next;
            partial_reg    <= partial_next;
            wp_reg         <= wp_next;
            bc_reg         <= bc_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        pk_reg        <= pk_next;
        pix_reg       <= pix_next;
        last_reg      <= last_next;
        code_reg      <= code_next;
        acc_reg       <= acc_next;
        nb_reg        <= nb_next;
        idx_reg       <= idx_next;
        disp_reg      <= disp_next;
        k_reg         <= k_next;
        slot_reg      <= slot_next;
        pend_addr_reg <= pend_addr_next;
        pend_byte_reg <= pend_byte_next;
        m_addr_reg    <= m_addr_next;
        m_byte_reg    <= m_byte_next;
        m_end_reg     <= m_end_next;
    end

    // Checks on the sequencer and the output hold stage.
    `GLC_ASSERT_IMPL(a_idle_nothing_held, s_ready, !pend_valid_reg)
    `GLC_ASSERT_IMPL(a_put_has_byte, state_reg == S_PUT, nb_reg >= NB_W'(8))
    `GLC_ASSERT_IMPL(a_cmp_after_read, state_reg == S_PRB_CMP, $past(state_reg) == S_PRB_RD)

endmodule

`default_nettype wire
